@@ rtl/core/wia_pkg.sv @@
// Package for the wide integer ALU: width constants, operation codes and
// the item structs for both channels. Depends on nothing else.
`default_nettype none

package wia_pkg;

  // Datapath width and the multiplier limb split derived from it
  localparam int VALUE_BITS     = 128;
  localparam int HIGH_BITS      = VALUE_BITS - 64;
  localparam int LIMB_BITS      = 32;
  localparam int NUM_LIMBS      = (VALUE_BITS + LIMB_BITS - 1) / LIMB_BITS;
  localparam int PAD_BITS       = NUM_LIMBS * LIMB_BITS;
  localparam int NUM_PROD       = NUM_LIMBS * (NUM_LIMBS + 1) / 2;
  localparam int PROD_BITS      = 2 * LIMB_BITS;
  localparam int DIAG_BITS      = PROD_BITS + $clog2(NUM_LIMBS);
  localparam int SHIFT_BITS     = 8;
  localparam int SHIFT_IDX_BITS = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_NEG  = 3'd3,
    OP_MUL  = 3'd4,
    OP_SHL  = 3'd5,
    OP_SHR  = 3'd6,
    OP_SAR  = 3'd7
  } op_t;

  typedef struct packed {
    op_t                    action;
    logic [63:0]            operand_a_low;
    logic [63:0]            operand_a_high;
    logic [63:0]            operand_b_low;
    logic [63:0]            operand_b_high;
    logic [SHIFT_BITS-1:0]  shift_amount;
    logic signed [63:0]     load_value;
  } req_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/wide_integer_alu.sv @@
// Wide two's-complement integer ALU: load, add, sub, negate, multiply and shifts.
// Throughput: one item per cycle while rsp_stall is low; the depth is set by
// the multiplier pipeline (32x32 limb products, diagonal sums, two-way merge,
// final add).
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on wia_pkg.
`default_nettype none

module wide_integer_alu (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire wia_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output wia_pkg::rsp_t      rsp
);
  import wia_pkg::*;

  // Stage registers
  logic                   s1_valid;
  req_t                   s1_req;
  logic                   s2_valid;
  logic                   s2_mul;
  logic [VALUE_BITS-1:0]  s2_alu;
  logic [PROD_BITS-1:0]   s2_prod [NUM_PROD];
  logic                   s3_valid;
  logic                   s3_mul;
  logic [VALUE_BITS-1:0]  s3_alu;
  logic [DIAG_BITS-1:0]   s3_diag [NUM_LIMBS];
  logic                   s4_valid;
  logic                   s4_mul;
  logic [VALUE_BITS-1:0]  s4_alu;
  logic [VALUE_BITS-1:0]  s4_even;
  logic [VALUE_BITS-1:0]  s4_odd;
  logic                   s5_valid;
  logic [VALUE_BITS-1:0]  s5_res;

  // Next values
  logic [VALUE_BITS-1:0]  s2_alu_next;
  logic [PROD_BITS-1:0]   s2_prod_next [NUM_PROD];
  logic [DIAG_BITS-1:0]   s3_diag_next [NUM_LIMBS];
  logic [VALUE_BITS-1:0]  s4_even_next;
  logic [VALUE_BITS-1:0]  s4_odd_next;

  // Stage load enables
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  // Let a stage load when it is empty or its content moves on
  assign s5_ready  = !s5_valid || !rsp_stall;
  assign s4_ready  = !s4_valid || s5_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req_stall = !s1_ready;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= req_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
    end
  end

  // Stage 1: capture the item
  always_ff @(posedge clk) begin
    if (s1_ready) s1_req <= req;
  end

  // Stage 2: limb products and the non-multiply operations
  logic [VALUE_BITS-1:0]     op_a, op_b, load_ext, sar_fill;
  logic [PAD_BITS-1:0]       a_pad, b_pad;
  logic                      shift_sat;
  logic [SHIFT_IDX_BITS-1:0] shift_idx;

  always_comb begin
    op_a      = {s1_req.operand_a_high[HIGH_BITS-1:0], s1_req.operand_a_low};
    op_b      = {s1_req.operand_b_high[HIGH_BITS-1:0], s1_req.operand_b_low};
    a_pad     = PAD_BITS'(op_a);
    b_pad     = PAD_BITS'(op_b);
    load_ext  = {{(VALUE_BITS-64){s1_req.load_value[63]}}, s1_req.load_value};
    shift_sat = s1_req.shift_amount >= SHIFT_BITS'(VALUE_BITS);
    shift_idx = s1_req.shift_amount[SHIFT_IDX_BITS-1:0];
    sar_fill  = {VALUE_BITS{op_a[VALUE_BITS-1]}};

    case (s1_req.action)
      OP_LOAD: s2_alu_next = load_ext;
      OP_ADD:  s2_alu_next = op_a + op_b;
      OP_SUB:  s2_alu_next = op_a - op_b;
      OP_NEG:  s2_alu_next = '0 - op_a;
      OP_SHL:  s2_alu_next = shift_sat ? '0 : op_a << shift_idx;
      OP_SHR:  s2_alu_next = shift_sat ? '0 : op_a >> shift_idx;
      OP_SAR:  s2_alu_next = shift_sat ? sar_fill
                                       : VALUE_BITS'($signed(op_a) >>> shift_idx);
      default: s2_alu_next = '0;
    endcase

    // Only products that land below the top limb boundary are formed
    for (int d = 0; d < NUM_LIMBS; d++) begin
      for (int i = 0; i <= d; i++) begin
        s2_prod_next[d*(d+1)/2 + i] =
          PROD_BITS'(a_pad[i*LIMB_BITS +: LIMB_BITS]) *
          PROD_BITS'(b_pad[(d-i)*LIMB_BITS +: LIMB_BITS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_mul  <= (s1_req.action == OP_MUL);
      s2_alu  <= s2_alu_next;
      s2_prod <= s2_prod_next;
    end
  end

  // Stage 3: sum each diagonal of equal weight
  always_comb begin
    for (int d = 0; d < NUM_LIMBS; d++) begin
      s3_diag_next[d] = '0;
      for (int i = 0; i <= d; i++) begin
        s3_diag_next[d] = s3_diag_next[d] + DIAG_BITS'(s2_prod[d*(d+1)/2 + i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_mul  <= s2_mul;
      s3_alu  <= s2_alu;
      s3_diag <= s3_diag_next;
    end
  end

  // Stage 4: merge even and odd diagonals at their weights
  always_comb begin
    s4_even_next = '0;
    s4_odd_next  = '0;
    for (int d = 0; d < NUM_LIMBS; d++) begin
      if ((d % 2) == 0) begin
        s4_even_next = s4_even_next + (VALUE_BITS'(s3_diag[d]) << (LIMB_BITS*d));
      end else begin
        s4_odd_next  = s4_odd_next + (VALUE_BITS'(s3_diag[d]) << (LIMB_BITS*d));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_mul  <= s3_mul;
      s4_alu  <= s3_alu;
      s4_even <= s4_even_next;
      s4_odd  <= s4_odd_next;
    end
  end

  // Stage 5: final product add and result select; hold while stalled
  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_res <= s4_mul ? (s4_even + s4_odd) : s4_alu;
    end
  end

  assign rsp_valid        = s5_valid;
  assign rsp.result_low   = s5_res[63:0];
  assign rsp.result_high  = 64'(s5_res[VALUE_BITS-1:64]);

`ifndef SYNTHESIS
  // Input stall only when every stage is full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && s2_valid && s3_valid && s4_valid && s5_valid && rsp_stall))
    else $error("input stalled with a free pipeline slot");

  // A load leaves a sign-extended value in stage 2
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_ready && s1_req.action == OP_LOAD) |=>
      ((&s2_alu[VALUE_BITS-1:63]) || !(|s2_alu[VALUE_BITS-1:63])))
    else $error("load result not sign-extended");

  // A taken result with a bubble behind it leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && !s4_valid) |=> !rsp_valid)
    else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire
